[src/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and types for the life generation stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

	localparam int unsigned GRID_W       = 7;
	localparam int unsigned COUNT_W      = 4;
	localparam int unsigned WINDOW_W     = 6;
	localparam int unsigned COLUMN_W     = 3;
	localparam int unsigned MAX_SIZE_DEF = 64;

	localparam logic [GRID_W-1:0]  GRID_RESET = GRID_W'(3);
	localparam logic [COUNT_W-1:0] BIRTH_CNT  = COUNT_W'(3);
	localparam logic [COUNT_W-1:0] KEEP_CNT   = COUNT_W'(2);

	// position flags of the cell being transferred in
	typedef struct packed {
		logic emit;
		logic last;
	} pos_t;

endpackage

`default_nettype wire

[src/life_generation_stencil.sv]
// One generation of Life (birth on 3, survival on 2 or 3) over a streamed
// grid. Cells of the padded frame (interior of side grid_size plus a one-cell
// halo ring) are transferred in raster order, one per clock when neither side
// stalls; each interior cell's next state and neighbor count come out once its
// lower-right neighbor has been transferred in, with last_cell marking the
// bottom-right interior cell. On its transfer an input cell is loaded into the
// input register together with the line RAM's registered read of the two rows
// above; from there it moves on to the result register. While a result waits
// under out_stall, an emitting cell holds in the input register and in_stall
// stays high. Writing grid_size restarts the frame and is to be done only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// life_generation_stencil
// Line-buffered 3x3 Life stencil with a result register on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module life_generation_stencil import lgs_pkg::*; #(
	parameter int unsigned MAX_SIZE = MAX_SIZE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [GRID_W-1:0]  cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               cell_alive,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    next_alive,
	output logic      [COUNT_W-1:0] neighbor_count,
	output logic                    last_cell
);

	localparam int unsigned AW    = $clog2(MAX_SIZE + 2);
	localparam int unsigned DEPTH = MAX_SIZE + 2;

	logic                in_xfer;
	logic [AW-1:0]       column;
	pos_t                pos;

	logic                valid_s1;
	logic                cell_s1;
	logic [AW-1:0]       column_s1;
	pos_t                pos_s1;
	logic                move_s1;

	logic [1:0]          line_rd;
	logic [1:0]          line_wr;
	logic [COLUMN_W-1:0] col_bits;
	logic [WINDOW_W-1:0] window_q;

	logic                alive;
	logic [COUNT_W-1:0]  count;

	assign in_xfer  = in_valid && !in_stall;
	assign move_s1  = valid_s1 && (!pos_s1.emit || !out_valid || !out_stall);
	assign in_stall = valid_s1 && !move_s1;

	lgs_frame_ctr #(
		.MAX_SIZE(MAX_SIZE)
	) u_frame_ctr (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.advance    (in_xfer),
		.column     (column),
		.pos        (pos)
	);

	// bit 0 upper line, bit 1 middle line; a column moves down one row per write
	lgs_ram #(
		.WIDTH(2),
		.DEPTH(DEPTH)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (move_s1),
		.wr_addr(column_s1),
		.wr_data(line_wr),
		.rd_en  (in_xfer),
		.rd_addr(column),
		.rd_data(line_rd)
	);

	assign line_wr  = {cell_s1, line_rd[1]};
	assign col_bits = {cell_s1, line_rd[1], line_rd[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cell_s1   <= cell_alive;
			column_s1 <= column;
			pos_s1    <= pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (cfg_wr_en) begin
			window_q <= '0;
		end else if (move_s1) begin
			window_q <= {window_q[2:0], col_bits};
		end
	end

	lgs_rule u_rule (
		.window(window_q),
		.column(col_bits),
		.alive (alive),
		.count (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (move_s1 && pos_s1.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && pos_s1.emit) begin
			next_alive     <= alive;
			neighbor_count <= count;
			last_cell      <= pos_s1.last;
		end
	end

`ifndef SYNTHESIS
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with stage 1 empty");

	a_emit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && pos_s1.emit) |=> out_valid)
		else $error("emitted cell did not reach the result register");

	a_alive_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && next_alive) |-> (neighbor_count == KEEP_CNT
			|| neighbor_count == BIRTH_CNT))
		else $error("live result with neighbor count other than two or three");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (neighbor_count <= COUNT_W'(8)))
		else $error("neighbor count above eight");
`endif

endmodule

`default_nettype wire

[src/lgs_ram.sv]
// ----------------------------------------------------------------------------
// lgs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 66
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[src/lgs_frame_ctr.sv]
// ----------------------------------------------------------------------------
// lgs_frame_ctr
// Grid size register and raster position counters over the padded frame.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_frame_ctr import lgs_pkg::*; #(
	parameter int unsigned MAX_SIZE = MAX_SIZE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [GRID_W-1:0]               cfg_wr_data,
	input  wire logic                            advance,
	output logic      [$clog2(MAX_SIZE+2)-1:0]   column,
	output pos_t                                 pos
);

	localparam int unsigned AW = $clog2(MAX_SIZE + 2);
	localparam int unsigned EW = (AW > GRID_W) ? AW : GRID_W;

	logic [GRID_W-1:0] grid_size_q;
	logic [AW-1:0]     col_q;
	logic [AW-1:0]     row_q;
	logic [EW-1:0]     grid_ext;
	logic [EW-1:0]     grid_clamped;
	logic [AW-1:0]     side_m1;
	logic              col_end;
	logic              row_end;

	// out-of-range sizes: zero acts as one, oversize as the maximum
	always_comb begin
		grid_ext = EW'(grid_size_q);
		if (grid_ext == '0) begin
			grid_clamped = EW'(1);
		end else if (grid_ext > EW'(MAX_SIZE)) begin
			grid_clamped = EW'(MAX_SIZE);
		end else begin
			grid_clamped = grid_ext;
		end
	end

	assign side_m1 = AW'(grid_clamped + EW'(1));
	assign col_end = (col_q >= side_m1);
	assign row_end = (row_q >= side_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_RESET;
			col_q       <= '0;
			row_q       <= '0;
		end else if (cfg_wr_en) begin
			grid_size_q <= cfg_wr_data;
			col_q       <= '0;
			row_q       <= '0;
		end else if (advance) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + AW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	assign column   = col_q;
	assign pos.emit = (row_q >= AW'(2)) && (col_q >= AW'(2)) && !(row_q > side_m1)
		&& !(col_q > side_m1);
	assign pos.last = (row_q == side_m1) && (col_q == side_m1);

endmodule

`default_nettype wire

[src/lgs_rule.sv]
// ----------------------------------------------------------------------------
// lgs_rule
// Neighbor count over the 3x3 window and the birth-on-3, survive-on-2-or-3 rule.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_rule import lgs_pkg::*; (
	input  wire logic [WINDOW_W-1:0] window,
	input  wire logic [COLUMN_W-1:0] column,
	output logic                     alive,
	output logic      [COUNT_W-1:0]  count
);

	logic [7:0] ring;
	logic       center;

	// window bit 1 is the middle of column c-1, i.e. the cell itself
	assign center = window[1];
	assign ring   = {column, window[5:2], window[0]};

	always_comb begin
		count = '0;
		for (int k = 0; k < 8; k++) begin
			count = count + COUNT_W'(ring[k]);
		end
	end

	assign alive = (count == BIRTH_CNT) || (center && (count == KEEP_CNT));

endmodule

`default_nettype wire
